// ===== sv/mpds_pkg.sv =====
// Shared types and constants for the multi-pattern DFA byte scanner.
// Used by the front end, the decoupling queue, the back end and the top level.
package mpds_pkg;

  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_TRANS = 2'd1;
  localparam logic [1:0] OP_MATCH = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  localparam int ENTRY_W     = 10;
  localparam int COUNT_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic               is_scan;
    logic [ENTRY_W-1:0] addr;
    logic [ENTRY_W-1:0] data;
    logic [COUNT_W-1:0] count;
  } q_item_t;

endpackage

// ===== sv/mpds_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mpds_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mpds_front.sv =====
// Front end: accepts transactions, folds case, steps the DFA state through the
// transition RAM and forwards scans and match writes to the queue. Uses mpds_pkg, mpds_ram.
module mpds_front #(
  parameter int STATE_COUNT   = 1024,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [mpds_pkg::BYTE_W-1:0]   in_byte,
  input  logic [mpds_pkg::ENTRY_W-1:0]  in_row,
  input  logic [mpds_pkg::ENTRY_W-1:0]  in_entry,
  input  logic [mpds_pkg::QLW-1:0]      q_level,
  output logic                          push,
  output mpds_pkg::q_item_t             push_item
);
  import mpds_pkg::*;

  localparam int ROWS  = (STATE_COUNT < (1 << ENTRY_W)) ? STATE_COUNT : (1 << ENTRY_W);
  localparam int ROW_W = $clog2(ROWS);
  localparam int DEPTH = ROWS * ALPHABET_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic               case_fold;
  logic [ROW_W-1:0]   st;
  logic [COUNT_W-1:0] cnt;
  logic               s1_valid;
  logic               s1_scan;
  logic               s1_zero;
  logic [ENTRY_W-1:0] s1_row;
  logic [ENTRY_W-1:0] s1_entry;
  logic [COUNT_W-1:0] s1_count;

  logic               accept;
  logic               fold_hit;
  logic [BYTE_W-1:0]  c;
  logic               c_ok;
  logic               col_ok;
  logic               row_ok;
  logic               ent_ok;
  logic [ROW_W-1:0]   t_rdata;
  logic [ROW_W-1:0]   cur;
  logic [AW-1:0]      scan_addr;
  logic [AW-1:0]      wr_addr;
  logic [ROW_W-1:0]   wr_data;
  logic               t_we;
  logic               t_re;
  logic [COUNT_W-1:0] cnt_inc;

  assign in_ready = ((QLW + 1)'(q_level) + (QLW + 1)'(s1_valid)) < (QLW + 1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  assign fold_hit = case_fold && (in_byte >= 8'h41) && (in_byte <= 8'h5A);
  assign c        = fold_hit ? (in_byte + 8'h20) : in_byte;
  assign c_ok     = {1'b0, c} < 9'(ALPHABET_SIZE);
  assign col_ok   = {1'b0, in_byte} < 9'(ALPHABET_SIZE);
  assign row_ok   = 32'(in_row) < 32'(STATE_COUNT);
  assign ent_ok   = 32'(in_entry) < 32'(STATE_COUNT);

  assign cur       = (s1_valid && s1_scan) ? (s1_zero ? '0 : t_rdata) : st;
  assign scan_addr = AW'(cur) * AW'(ALPHABET_SIZE) + AW'(c);
  assign wr_addr   = AW'(in_row[ROW_W-1:0]) * AW'(ALPHABET_SIZE) + AW'(in_byte);
  assign wr_data   = ent_ok ? in_entry[ROW_W-1:0] : '0;
  assign t_we      = accept && (in_op == OP_TRANS) && row_ok && col_ok;
  assign t_re      = accept && (in_op == OP_SCAN) && c_ok;
  assign cnt_inc   = (cnt == '1) ? cnt : cnt + 1'b1;

  mpds_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_trans_ram (
    .clk  (clk),
    .we   (t_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (t_re),
    .raddr(scan_addr),
    .rdata(t_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
    end else if (cfg_we) begin
      case_fold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      cnt      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && ((in_op == OP_SCAN) || ((in_op == OP_MATCH) && row_ok));
      if (accept && (in_op == OP_START)) begin
        st  <= '0;
        cnt <= '0;
      end else begin
        st <= cur;
        if (accept && (in_op == OP_SCAN)) begin
          cnt <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_scan  <= (in_op == OP_SCAN);
      s1_zero  <= !c_ok;
      s1_row   <= in_row;
      s1_entry <= in_entry;
      s1_count <= cnt_inc;
    end
  end

  always_comb begin
    push              = s1_valid;
    push_item.is_scan = s1_scan;
    push_item.addr    = s1_scan ? ENTRY_W'(cur) : s1_row;
    push_item.data    = s1_entry;
    push_item.count   = s1_count;
  end

endmodule

// ===== sv/mpds_queue.sv =====
// Short FIFO that decouples the front end from the back end.
// Uses mpds_pkg.
module mpds_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  mpds_pkg::q_item_t        push_item,
  input  logic                     pop,
  output logic                     head_valid,
  output mpds_pkg::q_item_t        head,
  output logic [mpds_pkg::QLW-1:0] level
);
  import mpds_pkg::*;

  q_item_t        mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;

  assign head_valid = (level != '0);
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mpds_back.sv =====
// Back end: applies match-table writes, looks up the match entry of each scanned
// state and holds the result in an output register. Uses mpds_pkg, mpds_ram.
module mpds_back #(
  parameter int STATE_COUNT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  mpds_pkg::q_item_t             head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [mpds_pkg::ENTRY_W-1:0]  out_index,
  output logic [mpds_pkg::COUNT_W-1:0]  out_count
);
  import mpds_pkg::*;

  localparam int ROWS  = (STATE_COUNT < (1 << ENTRY_W)) ? STATE_COUNT : (1 << ENTRY_W);
  localparam int ROW_W = $clog2(ROWS);

  logic               m_valid;
  logic [COUNT_W-1:0] m_count;
  logic [ENTRY_W-1:0] m_rdata;
  logic               out_load;
  logic               m_adv;
  logic               m_we;
  logic               m_re;

  assign out_load = m_valid && (!out_valid || out_ready);
  assign m_adv    = !m_valid || out_load;
  assign pop      = head_valid && (!head.is_scan || m_adv);
  assign m_we     = pop && !head.is_scan;
  assign m_re     = pop && head.is_scan;

  mpds_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ROWS)
  ) u_match_ram (
    .clk  (clk),
    .we   (m_we),
    .waddr(head.addr[ROW_W-1:0]),
    .wdata(head.data),
    .re   (m_re),
    .raddr(head.addr[ROW_W-1:0]),
    .rdata(m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_adv) begin
        m_valid <= m_re;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_re) begin
      m_count <= head.count;
    end
    if (out_load) begin
      out_hit   <= (m_rdata != '0);
      out_index <= (m_rdata != '0) ? (m_rdata - 1'b1) : '0;
      out_count <= m_count;
    end
  end

endmodule

// ===== sv/multi_pattern_dfa_scanner_top.sv =====
// Top level of the multi-pattern DFA byte scanner: front end, queue, back end.
// Uses mpds_pkg, mpds_front, mpds_queue, mpds_back.
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser op, tdata byte/row/entry
//   m_axis    out        m_axis_tvalid/m_axis_tready  tuser hit, tdata index/offset
//   cfg       in         cfg_we                       cfg_wdata case fold
//
// One transaction is taken per cycle while s_axis_tready is high; a scan result
// passes the front stage, queue, match RAM read and output register. The rate is
// set by the transition RAM read, whose output forms the next scan's address.
// Reset clears no table contents. A stalled output holds its register, so the
// four-entry queue fills; s_axis_tready drops when queue and front stage hold four.
module multi_pattern_dfa_scanner_top #(
  parameter int STATE_COUNT   = 1024,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Bits from the lowest up: byte_value[7:0], row[17:8], entry[27:18], zero.
  input  logic [mpds_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Bits from the lowest up: op[1:0].
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Bits from the lowest up: word_index[9:0], end_offset[41:10], zero.
  output logic [mpds_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Bits from the lowest up: hit[0].
  output logic                               m_axis_tuser
);
  import mpds_pkg::*;

  logic               push;
  q_item_t            push_item;
  logic               pop;
  logic               head_valid;
  q_item_t            head;
  logic [QLW-1:0]     q_level;
  logic [ENTRY_W-1:0] out_index;
  logic [COUNT_W-1:0] out_count;

  mpds_front #(
    .STATE_COUNT  (STATE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_byte  (s_axis_tdata[7:0]),
    .in_row   (s_axis_tdata[17:8]),
    .in_entry (s_axis_tdata[27:18]),
    .q_level  (q_level),
    .push     (push),
    .push_item(push_item)
  );

  mpds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head),
    .level     (q_level)
  );

  mpds_back #(
    .STATE_COUNT(STATE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_hit   (m_axis_tuser),
    .out_index (out_index),
    .out_count (out_count)
  );

  assign m_axis_tdata = {6'd0, out_count, out_index};

endmodule

// ===== sv/mpds_checker.sv =====
// Port-level checker for the multi-pattern DFA byte scanner, bound to the top level.
// Depends only on the top level's ports.
module mpds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_idle_after_reset: assert property (@(posedge clk) ($past(rst) && !rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk) ($past(rst) && !rst) |-> s_axis_tready)
    else $error("input not ready right after reset");

  a_no_hit_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:0] == 10'd0))
    else $error("word index nonzero on a result without a hit");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind multi_pattern_dfa_scanner_top mpds_checker u_chk (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_pattern_dfa_scanner_top: loads DFA tables, scans
// byte streams under both case-fold settings and checks every scan report.
// Depends on mpds_pkg and the scanner RTL.
module testbench;
  import mpds_pkg::*;

  localparam int STATE_COUNT   = 1024;
  localparam int ALPHABET_SIZE = 256;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_ITEMS   = 600;

  typedef struct packed {
    logic [1:0]         op;
    logic [BYTE_W-1:0]  byte_value;
    logic [ENTRY_W-1:0] row;
    logic [ENTRY_W-1:0] entry;
  } stream_item_t;

  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] word_index;
    logic [COUNT_W-1:0] end_offset;
  } scan_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  multi_pattern_dfa_scanner_top #(
    .STATE_COUNT(STATE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stream_item_t pending_items[$];
  scan_report_t expected_reports[$];
  int items_queued = 0;
  int items_taken = 0;
  int results_owed = 0;
  int errors = 0;
  int cycle_count = 0;
  int scans_seen = 0;
  int writes_seen = 0;
  int hits_due = 0;
  bit in_taken = 1'b0;

  // Stimulus planning: tracks which table entries have been written so that
  // no scan ever reads an entry that was never loaded.
  int plan_next[STATE_COUNT*ALPHABET_SIZE];
  bit plan_has_match[STATE_COUNT];
  int match_rows[$];
  int plan_state = 0;
  bit plan_fold = 1'b0;

  // Predicted scanner state.
  logic [ENTRY_W-1:0] dfa_next[STATE_COUNT*ALPHABET_SIZE];
  logic [ENTRY_W-1:0] match_word[STATE_COUNT];
  logic [ENTRY_W-1:0] dfa_state = '0;
  logic [COUNT_W-1:0] bytes_scanned = '0;
  logic fold_on = 1'b0;

  function automatic logic [7:0] fold_case(logic [7:0] b, logic f);
    return (f && b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function automatic int draw_gap(bit rush);
    int r;
    r = $urandom_range(99);
    if (rush || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int pick_target();
    return match_rows[$urandom_range(match_rows.size() - 1)];
  endfunction

  task automatic queue_item(logic [1:0] op, logic [7:0] bv, logic [9:0] r, logic [9:0] e);
    stream_item_t it;
    it.op = op;
    it.byte_value = bv;
    it.row = r;
    it.entry = e;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic plan_match(int r, int e);
    if (!plan_has_match[r]) begin
      plan_has_match[r] = 1'b1;
      match_rows.push_back(r);
    end
    queue_item(OP_MATCH, 8'($urandom), 10'(r), 10'(e));
  endtask

  task automatic plan_trans(int r, int c, int e);
    plan_next[r*ALPHABET_SIZE + c] = e;
    queue_item(OP_TRANS, 8'(c), 10'(r), 10'(e));
  endtask

  task automatic plan_scan(logic [7:0] b);
    int slot;
    slot = plan_state*ALPHABET_SIZE + fold_case(b, plan_fold);
    if (plan_next[slot] < 0)
      plan_trans(plan_state, fold_case(b, plan_fold), pick_target());
    plan_state = plan_next[slot];
    queue_item(OP_SCAN, b, 10'($urandom), 10'($urandom));
  endtask

  task automatic plan_start();
    plan_state = 0;
    queue_item(OP_START, 8'($urandom), 10'($urandom), 10'($urandom));
  endtask

  task automatic plan_random_phase();
    logic [7:0] pool[8];
    int roll;
    int r;
    int phase_end;
    foreach (pool[i]) begin
      case ($urandom_range(2))
        0: pool[i] = 8'(8'h61 + $urandom_range(25));
        1: pool[i] = 8'(8'h41 + $urandom_range(25));
        default: pool[i] = 8'($urandom_range(255));
      endcase
    end
    phase_end = items_queued + PHASE_ITEMS;
    while (items_queued < phase_end) begin
      roll = $urandom_range(99);
      r = $urandom_range(1) ? pick_target() : $urandom_range(STATE_COUNT - 1);
      if (roll < 78)
        plan_scan($urandom_range(9) < 7 ? pool[$urandom_range(7)] : 8'($urandom_range(255)));
      else if (roll < 86)
        plan_trans(r, $urandom_range(ALPHABET_SIZE - 1), pick_target());
      else if (roll < 94)
        plan_match(r, $urandom_range(2) == 0 ? 0 : $urandom_range(1023));
      else
        plan_start();
    end
  endtask

  task automatic settle();
    wait (items_taken == items_queued && results_owed == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_fold(bit v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    plan_fold = v;
  endtask

  initial begin
    foreach (plan_next[i]) plan_next[i] = -1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan_match(0, 0);
    plan_match(1, 1);
    plan_match(1023, 1023);
    plan_match(2, 0);
    plan_match(512, 512);
    plan_trans(0, 8'h61, 1);
    plan_trans(1, 8'hFF, 1023);
    plan_trans(1023, 8'h00, 2);
    plan_trans(2, 8'h80, 512);
    plan_trans(512, 8'h41, 0);
    plan_trans(0, 8'h41, 2);
    plan_scan(8'h61);
    plan_scan(8'hFF);
    plan_scan(8'h00);
    plan_scan(8'h80);
    plan_scan(8'h41);
    plan_scan(8'h41);
    plan_start();
    plan_scan(8'h61);
    settle();

    write_fold(1'b1);
    plan_start();
    plan_scan(8'h41);
    plan_scan(8'h5A);
    plan_scan(8'h5B);
    plan_scan(8'h40);
    plan_random_phase();
    settle();

    write_fold(1'b0);
    plan_random_phase();
    settle();

    write_fold(1'b1);
    plan_random_phase();
    settle();

    $display("Scanned %0d bytes and applied %0d table writes under both case-fold settings.",
             scans_seen, writes_seen);
    $display("%0d of the scan reports carried a keyword hit.", hits_due);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Input driver.
  stream_item_t send_item;
  int send_gap = 0;
  bit send_rush = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        send_item = pending_items.pop_front();
        s_axis_tdata <= {4'b0, send_item.entry, send_item.row, send_item.byte_value};
        s_axis_tuser <= send_item.op;
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(63) == 0) send_rush = !send_rush;
        send_gap = draw_gap(send_rush);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  int recv_stall = 0;
  bit recv_rush = 1'b0;
  logic long_hold = 1'b0;
  int hold_clock = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold) begin
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(63) == 0) recv_rush = !recv_rush;
      recv_stall = draw_gap(recv_rush);
    end
  end

  // The receiver periodically holds off so that the queue fills and the input stalls.
  always @(negedge clk) begin
    if (rst) begin
      long_hold <= 1'b0;
    end else begin
      hold_clock++;
      long_hold <= (hold_clock % 1500) >= 1420;
    end
  end

  // Prediction on each input transaction and checking on each output transaction.
  always @(posedge clk) begin : check
    stream_item_t it;
    scan_report_t want;
    logic [7:0] col;
    logic [ENTRY_W-1:0] m;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      in_taken = !rst && s_axis_tvalid && s_axis_tready;
      if (!rst && cfg_we) fold_on = cfg_wdata;
      if (in_taken) begin
        items_taken++;
        it.op = s_axis_tuser;
        {it.entry, it.row, it.byte_value} = s_axis_tdata[27:0];
        case (it.op)
          OP_TRANS: begin
            writes_seen++;
            if (it.row < STATE_COUNT && it.byte_value < ALPHABET_SIZE)
              dfa_next[it.row*ALPHABET_SIZE + it.byte_value] =
                (it.entry < STATE_COUNT) ? it.entry : '0;
          end
          OP_MATCH: begin
            writes_seen++;
            if (it.row < STATE_COUNT) match_word[it.row] = it.entry;
          end
          OP_START: begin
            dfa_state = '0;
            bytes_scanned = '0;
          end
          OP_SCAN: begin
            scans_seen++;
            col = fold_case(it.byte_value, fold_on);
            if (col < ALPHABET_SIZE && dfa_state < STATE_COUNT)
              dfa_state = dfa_next[dfa_state*ALPHABET_SIZE + col];
            else
              dfa_state = '0;
            if (dfa_state >= STATE_COUNT) dfa_state = '0;
            if (bytes_scanned != '1) bytes_scanned++;
            m = match_word[dfa_state];
            want.hit = (m != 0);
            want.word_index = (m != 0) ? ENTRY_W'(m - 1) : '0;
            want.end_offset = bytes_scanned;
            if (want.hit) hits_due++;
            expected_reports.push_back(want);
            results_owed++;
          end
          default: ;
        endcase
      end
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected scan report: hit %0d word_index %0d end_offset %0d",
                 m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[41:10]);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          results_owed--;
          if (m_axis_tuser !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[9:0] !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, m_axis_tdata[9:0]);
            errors++;
          end
          if (m_axis_tdata[41:10] !== want.end_offset) begin
            $error("end_offset: expected %0d, got %0d", want.end_offset,
                   m_axis_tdata[41:10]);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== multi_pattern_dfa_scanner_top.f =====
sv/mpds_pkg.sv
sv/mpds_ram.sv
sv/mpds_front.sv
sv/mpds_queue.sv
sv/mpds_back.sv
sv/multi_pattern_dfa_scanner_top.sv
sv/mpds_checker.sv
tb/testbench.sv
